>>> src/btpl_pkg.sv
package btpl_pkg;

   // fixed field widths
   localparam int POS_W  = 32;
   localparam int CNT_W  = 32;
   localparam int BASE_W = 33;
   localparam int DOM_W  = 32;
   localparam int IN_W   = 64;

   // defaults for the top-level parameters
   localparam int DEFAULT_WORD_BITS   = 64;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             has_position;
      logic             last_of_word;
      logic [CNT_W-1:0] set_count;
   } rsp_item_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] val);
      logic [CNT_W-1:0] res;
      res = (val == CNT_MAX) ? CNT_MAX : val + CNT_W'(1);
      return res;
   endfunction

endpackage

>>> src/btpl_front.sv
module btpl_front #(
   parameter int WORD_BITS = btpl_pkg::DEFAULT_WORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [btpl_pkg::DOM_W-1:0]  csr_wdata,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [btpl_pkg::IN_W-1:0]   in_word,
   input  logic                        in_first,
   output logic                        push,
   input  logic                        q_full,
   output logic [WORD_BITS+btpl_pkg::POS_W:0] push_data
);
   import btpl_pkg::*;

   localparam int SPAN_W = $clog2(WORD_BITS + 1);

   logic [DOM_W-1:0]     domain_ff, domain_in;
   logic [BASE_W-1:0]    word_base_ff, word_base_in;
   logic [BASE_W-1:0]    eff_base;
   logic [BASE_W-1:0]    span;
   logic                 in_dom;
   logic                 full_word;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] masked;

   always_comb begin
      eff_base  = in_first ? '0 : word_base_ff;
      in_dom    = eff_base < {1'b0, domain_ff};
      span      = {1'b0, domain_ff} - eff_base;
      full_word = span >= BASE_W'(WORD_BITS);
      if (!in_dom) begin
         mask = '0;
      end else if (full_word) begin
         mask = '1;
      end else begin
         mask = ~({WORD_BITS{1'b1}} << span[SPAN_W-1:0]);
      end
      masked    = in_word[WORD_BITS-1:0] & mask;
      in_ready  = !q_full;
      push      = in_valid && !q_full;
      push_data = {in_first, eff_base[POS_W-1:0], masked};
      // base stops moving once it passes the largest domain
      word_base_in = word_base_ff;
      if (push) begin
         word_base_in = eff_base[BASE_W-1] ? eff_base : eff_base + BASE_W'(WORD_BITS);
      end
      domain_in = csr_we ? csr_wdata : domain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         domain_ff    <= '0;
         word_base_ff <= '0;
      end else begin
         domain_ff    <= domain_in;
         word_base_ff <= word_base_in;
      end
   end

endmodule

>>> src/btpl_queue.sv
module btpl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = btpl_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import btpl_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_QW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      full       = fill_ff == CNT_QW'(DEPTH);
      head_valid = fill_ff != '0;
      head_data  = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in    = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> src/btpl_back.sv
module btpl_back #(
   parameter int WORD_BITS = btpl_pkg::DEFAULT_WORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  logic [WORD_BITS+btpl_pkg::POS_W:0] q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output btpl_pkg::rsp_item_type             rsp_item
);
   import btpl_pkg::*;

   localparam int IDX_W = $clog2(WORD_BITS);

   logic                 cur_valid_ff, cur_valid_in;
   logic [WORD_BITS-1:0] cur_word_ff, cur_word_in;
   logic [POS_W-1:0]     cur_base_ff, cur_base_in;
   logic                 cur_first_ff, cur_first_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_ff, rsp_in;

   logic                 step;
   logic                 load;
   logic                 empty;
   logic [WORD_BITS-1:0] rest;
   logic [IDX_W-1:0]     idx;
   logic [CNT_W-1:0]     cnt_start;
   rsp_item_type         item;

   // lowest set bit of the working word
   always_comb begin
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (cur_word_ff[i]) begin
            idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      step      = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
      cnt_start = cur_first_ff ? '0 : count_ff;
      empty     = cur_word_ff == '0;
      rest      = cur_word_ff & (cur_word_ff - WORD_BITS'(1));

      item.has_position = !empty;
      item.last_of_word = empty || (rest == '0);
      item.position     = empty ? '0 : cur_base_ff + POS_W'(idx);
      item.set_count    = empty ? cnt_start : sat_inc(cnt_start);

      load  = q_valid && (!cur_valid_ff || (step && item.last_of_word));
      q_pop = load;

      cur_valid_in = cur_valid_ff;
      cur_word_in  = cur_word_ff;
      cur_base_in  = cur_base_ff;
      cur_first_in = cur_first_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         cur_word_in  = q_data[WORD_BITS-1:0];
         cur_base_in  = q_data[WORD_BITS+POS_W-1:WORD_BITS];
         cur_first_in = q_data[WORD_BITS+POS_W];
      end else if (step) begin
         cur_valid_in = !item.last_of_word;
         cur_word_in  = rest;
         cur_first_in = 1'b0;
      end

      count_in     = step ? item.set_count : count_ff;
      rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
      rsp_in       = step ? item : rsp_ff;

      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      cur_word_ff <= cur_word_in;
      cur_base_ff <= cur_base_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_first_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_first_ff <= cur_first_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/bitmap_to_position_list.sv
// Channel   | Dir | Bus / bits                                   | Moves
// ----------+-----+----------------------------------------------+------------------------
// req_*     | in  | tdata[63:0] bitmap_word, tuser[0] first_word | one bitmap word
// rsp_*     | out | tdata[31:0] position, [63:32] set_count,     | one position (or empty)
//           |     | tuser[0] has_position, tlast last_of_word    |
// csr_*     | in  | wdata[31:0] domain_bits                      | register write
//
// A word whose masked content has k set bits gives max(k,1) rsp transfers, one per cycle
// unless rsp stalls, paced by the back end's lowest-set-bit search. Words with at most one
// set bit sustain one req transfer per cycle; each word passes the queue, working word and
// output registers before its first rsp. Reset (synchronous) clears the domain to 0, the
// position base and count, and the queue. An rsp stall backs up through the output register
// and the word queue before req_tready drops; req stalls leave the back end draining.
module bitmap_to_position_list #(
   parameter int WORD_BITS   = btpl_pkg::DEFAULT_WORD_BITS,
   parameter int QUEUE_DEPTH = btpl_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // register port
   input  logic                          csr_we,
   input  logic [btpl_pkg::DOM_W-1:0]    csr_wdata,   // domain_bits
   // word stream in
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [btpl_pkg::IN_W-1:0]     req_tdata,   // [63:0] bitmap_word
   input  logic [0:0]                    req_tuser,   // [0] first_word
   // position stream out
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,   // [31:0] position, [63:32] set_count
   output logic [0:0]                    rsp_tuser,   // [0] has_position
   output logic                          rsp_tlast    // last_of_word
);
   import btpl_pkg::*;

   localparam int ENTRY_W = WORD_BITS + POS_W + 1;

   // front -> queue
   logic               push;
   logic               q_full;
   logic [ENTRY_W-1:0] push_data;
   // queue -> back
   logic               q_valid;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_data;
   // back -> ports
   rsp_item_type       item;

   // Front: applies first_word, masks off bits past the domain end, tracks word base.
   btpl_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_word   (req_tdata),
      .in_first  (req_tuser[0]),
      .push      (push),
      .q_full    (q_full),
      .push_data (push_data)
   );

   // Short word queue decouples classification from position emission.
   btpl_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   // Back: peels off one set bit per cycle while rsp is not stalled, keeps the running count.
   btpl_back #(.WORD_BITS(WORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (item)
   );

   assign rsp_tdata    = {item.set_count, item.position};
   assign rsp_tuser[0] = item.has_position;
   assign rsp_tlast    = item.last_of_word;

   // an empty result always closes its word
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("empty result without tlast");

   // an empty result carries position zero
   a_empty_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == '0)
      else $error("empty result with nonzero position");

   // a reported position has been counted
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[63:32] != '0)
      else $error("position reported with zero count");

endmodule

>>> verif/tb_bitmap_to_position_list.sv
`timescale 1ns / 1ps

module tb_bitmap_to_position_list;
   import btpl_pkg::*;

   localparam int WORD_BITS    = DEFAULT_WORD_BITS;
   localparam int MAX_REPORTS  = 10;
   localparam int LONG_HOLD    = 300;   // rsp stall long enough to back up the word queue
   localparam longint unsigned BASE_CEILING = 64'h1_0000_0000;

   // ---------------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------------------------
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_we     = 1'b0;
   logic [DOM_W-1:0]    csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [IN_W-1:0]     req_tdata  = '0;    // [63:0] bitmap_word
   logic [0:0]          req_tuser  = '0;    // [0] first_word
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [63:0]         rsp_tdata;          // [31:0] position, [63:32] set_count
   logic [0:0]          rsp_tuser;          // [0] has_position
   logic                rsp_tlast;          // last_of_word

   always #5 clock = ~clock;

   bitmap_to_position_list #(
      .WORD_BITS (WORD_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------------------
   // predictor state: mirrors the block's domain register, position base and count
   // ---------------------------------------------------------------------------------
   logic [DOM_W-1:0]    dom_limit   = '0;   // reset value of the register
   longint unsigned     base_pos    = 0;    // global position of bit 0 of the next word
   logic [CNT_W-1:0]    ones_total  = '0;   // saturating count of in-domain set bits

   rsp_item_type        pending_positions[$];   // expected rsp transfers, oldest first

   // knobs for the two idling processes
   bit                  sender_gaps_on   = 1'b1;
   bit                  receiver_stall_on = 1'b1;
   int                  hold_request     = 0;   // one-shot long rsp stall, in cycles

   // bookkeeping
   int                  fail_count    = 0;
   int                  words_sent    = 0;
   int                  positions_got = 0;
   int                  empties_got   = 0;
   int                  domain_writes = 0;
   int                  long_holds    = 0;

   // ---------------------------------------------------------------------------------
   // predictor: expand one accepted word into its expected position transfers
   // ---------------------------------------------------------------------------------
   task automatic expand_word(input logic [IN_W-1:0] word, input bit first);
      logic [63:0]  live;
      rsp_item_type item;
      int           k;
      if (first) begin
         base_pos   = 0;
         ones_total = '0;
      end
      // keep only bits below the domain end; positions grow with k, so this is a prefix
      live = '0;
      for (k = 0; k < WORD_BITS; k++) begin
         if (base_pos + 64'(k) < 64'(dom_limit)) live[k] = word[k];
      end
      if (live == '0) begin
         // nothing qualifies: one empty transfer carrying the unchanged count
         item = '{position: '0, has_position: 1'b0, last_of_word: 1'b1,
                  set_count: ones_total};
         pending_positions = {pending_positions, item};
      end else begin
         for (k = 0; k < WORD_BITS; k++) begin
            if (live[k]) begin
               if (ones_total != CNT_MAX) ones_total = ones_total + 1'b1;
               item = '{position: POS_W'(base_pos + 64'(k)), has_position: 1'b1,
                        last_of_word: ((live >> (k + 1)) == '0), set_count: ones_total};
               pending_positions = {pending_positions, item};
            end
         end
      end
      // base stops advancing once it is past any possible domain
      if (base_pos < BASE_CEILING) base_pos += WORD_BITS;
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t ERROR %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------------------
   // sender: one word per call, random gap first, predicts on the accepting edge
   // valid is never lowered here after the transfer; the next call or drain does that
   // ---------------------------------------------------------------------------------
   task automatic send_word(input logic [IN_W-1:0] word, input bit first);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expand_word(word, first);
      words_sent++;
   endtask

   // stop offering and wait until every expected transfer has come out
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
   endtask

   // register writes only with the block idle
   task automatic write_domain(input logic [DOM_W-1:0] value);
      drain();
      @(negedge clock);
      csr_we      <= 1'b1;
      csr_wdata   <= value;
      dom_limit    = value;
      @(negedge clock);
      csr_we      <= 1'b0;
      domain_writes++;
   endtask

   // random word shapes: full random, sparse, dense, empty, full, single bit
   function automatic logic [IN_W-1:0] pick_word();
      logic [IN_W-1:0] w;
      int              n;
      w = '0;
      case ($urandom_range(0, 5))
         0: w = {$urandom, $urandom};
         1: begin
            for (n = $urandom_range(1, 4); n > 0; n--) w[$urandom_range(0, 63)] = 1'b1;
         end
         2: begin
            w = '1;
            for (n = $urandom_range(1, 4); n > 0; n--) w[$urandom_range(0, 63)] = 1'b0;
         end
         3: w = '0;
         4: w = '1;
         default: w[$urandom_range(0, 63)] = 1'b1;
      endcase
      return w;
   endfunction

   // ---------------------------------------------------------------------------------
   // receiver: random stall before each rsp transfer, plus the one-shot long hold
   // ---------------------------------------------------------------------------------
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
            long_holds++;
         end
         gap = receiver_stall_on ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------------------
   // checker: every rsp transfer against the oldest expectation
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{position: rsp_tdata[31:0], has_position: rsp_tuser[0],
                 last_of_word: rsp_tlast, set_count: rsp_tdata[63:32]};
         if (got.has_position) positions_got++;
         else empties_got++;
         if (pending_positions.size() == 0) begin
            note_failure($sformatf("unexpected rsp: pos=%0d has=%0b last=%0b cnt=%0d",
                                   got.position, got.has_position, got.last_of_word,
                                   got.set_count));
         end else begin
            want = pending_positions.pop_front();
            if (got !== want)
               note_failure($sformatf({"rsp mismatch: exp pos=%0d has=%0b last=%0b cnt=%0d",
                                       " / got pos=%0d has=%0b last=%0b cnt=%0d"},
                                      want.position, want.has_position, want.last_of_word,
                                      want.set_count, got.position, got.has_position,
                                      got.last_of_word, got.set_count));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   // reset leaves the domain at 0, so everything is masked off
   task automatic test_reset_domain();
      send_word('1, 1'b1);
      send_word({$urandom, $urandom}, 1'b0);
   endtask

   // domain ends two bits into the third word; walk across that boundary and past it
   task automatic test_boundaries();
      write_domain(130);
      send_word('1, 1'b1);                      // 0..63, all set
      send_word('0, 1'b0);                      // empty word, count held at 64
      send_word('1, 1'b0);                      // 128, 129 only
      send_word('1, 1'b0);                      // entirely past the domain
      send_word(64'h8000_0000_0000_0001, 1'b1); // restart; lowest and highest bit
      send_word(64'h0000_0000_0000_0001, 1'b1);
      send_word(64'h8000_0000_0000_0000, 1'b0); // position 127
      send_word('0, 1'b1);                      // empty first word clears the count
   endtask

   // register extremes, an exact word multiple, and a change in the middle of a bitmap
   task automatic test_domain_edges();
      write_domain('0);
      send_word('1, 1'b1);
      write_domain(64);
      send_word('1, 1'b1);
      send_word('1, 1'b0);                      // base 64 is already past the end
      write_domain('1);                         // base and count carry over
      send_word('1, 1'b0);
      send_word({$urandom, $urandom}, 1'b0);
      write_domain(1);
      send_word('1, 1'b1);                      // only position 0
      send_word('1, 1'b0);
   endtask

   // well-formed bitmaps with random content under a few random domains
   task automatic test_random_bitmaps(input int phases, input int words_per_phase);
      logic [DOM_W-1:0] dom;
      int               p;
      int               i;
      for (p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0:       dom = $urandom_range(1, 64 * 12);
            1:       dom = 64 * $urandom_range(1, 10);
            2:       dom = '1;
            default: dom = $urandom;
         endcase
         write_domain(dom);
         for (i = 0; i < words_per_phase; i++)
            send_word(pick_word(), (i == 0) || ($urandom_range(0, 7) == 0));
      end
   endtask

   // back-to-back on both sides
   task automatic test_full_rate(input int words);
      int i;
      drain();
      sender_gaps_on    = 1'b0;
      receiver_stall_on = 1'b0;
      write_domain(64 * 4 + 17);
      for (i = 0; i < words; i++) send_word(pick_word(), (i % 5) == 0);
      drain();
      sender_gaps_on    = 1'b1;
      receiver_stall_on = 1'b1;
   endtask

   // rsp held off for a long stretch while dense words keep coming: req_tready must drop
   task automatic test_backpressure(input int words);
      int i;
      write_domain('1);
      sender_gaps_on = 1'b0;
      hold_request   = LONG_HOLD;
      for (i = 0; i < words; i++) send_word((i % 3 == 0) ? pick_word() : '1, i == 0);
      sender_gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_domain();
      test_boundaries();
      test_domain_edges();
      test_random_bitmaps(4, 26);
      test_full_rate(20);
      test_backpressure(20);

      drain();
      repeat (20) @(posedge clock);   // catch anything extra behind the last transfer

      $display("run: %0d words in, %0d positions and %0d empty words out",
               words_sent, positions_got, empties_got);
      $display("run: %0d domain writes, %0d long rsp holds", domain_writes, long_holds);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog: well beyond the slowest legal run (every word dense, every rsp stalled)
   initial begin
      #10_000_000;
      $display("timeout with %0d transfers outstanding", pending_positions.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
